@@ sv/irpd_pkg.sv @@
// ----------------------------------------------------------------------------
// IR pulse-distance decoder package
// Shared types, register indexes, status codes and reset values.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int unsigned CntW      = 16;
  localparam int unsigned FrameW    = 32;
  localparam int unsigned BitIdxW   = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned FifoDepth = 2;

  localparam logic [CntW-1:0] LeaderMinRst = 16'd6248;
  localparam logic [CntW-1:0] LeaderMaxRst = 16'd11060;
  localparam logic [CntW-1:0] SpaceMinRst  = 16'd3124;
  localparam logic [CntW-1:0] SpaceMaxRst  = 16'd6248;
  localparam logic [CntW-1:0] OneMinRst    = 16'd1041;
  localparam logic [CntW-1:0] OneMaxRst    = 16'd1823;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEADER_MIN = 3'd0,
    REG_LEADER_MAX = 3'd1,
    REG_SPACE_MIN  = 3'd2,
    REG_SPACE_MAX  = 3'd3,
    REG_ONE_MIN    = 3'd4,
    REG_ONE_MAX    = 3'd5
  } irpd_reg_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LEADER = 2'd1,
    ST_SPACE  = 2'd2,
    ST_COMPL  = 2'd3
  } irpd_status_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEADER = 3'd1,
    PH_SPACE  = 3'd2,
    PH_MARK   = 3'd3,
    PH_HIGH   = 3'd4
  } irpd_phase_e;

  typedef struct packed {
    logic [CntW-1:0] leader_min;
    logic [CntW-1:0] leader_max;
    logic [CntW-1:0] space_min;
    logic [CntW-1:0] space_max;
    logic [CntW-1:0] one_min;
    logic [CntW-1:0] one_max;
  } irpd_cfg_t;

  // strict window test: lo < v < hi
  function automatic logic in_window(logic [CntW-1:0] v, logic [CntW-1:0] lo,
                                     logic [CntW-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

@@ sv/irpd_sample_queue.sv @@
// ----------------------------------------------------------------------------
// IR pulse-distance decoder sample queue
// Front end: accepts line samples and buffers them for the decode engine.
// ----------------------------------------------------------------------------
module irpd_sample_queue #(
  parameter int unsigned Depth = irpd_pkg::FifoDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic ir_level_i,
  output logic q_valid_o,
  output logic q_level_o,
  input  logic q_pop_i
);
  import irpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntQW-1:0] FullCnt = CntQW'(Depth);

  logic [Depth-1:0] mem_q;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_stall_o = (cnt_q == FullCnt);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != '0);
  assign q_valid_o  = (cnt_q != '0);
  assign q_level_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ir_level_i;
    end
  end

endmodule

@@ sv/irpd_decode.sv @@
// ----------------------------------------------------------------------------
// IR pulse-distance decoder engine
// Back end: times leader, space and data bits; holds the result word.
// ----------------------------------------------------------------------------
module irpd_decode (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  irpd_pkg::irpd_cfg_t    cfg_i,
  input  logic                   q_valid_i,
  input  logic                   q_level_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [irpd_pkg::FrameW-1:0] frame_o,
  output irpd_pkg::irpd_status_e status_o
);
  import irpd_pkg::*;

  irpd_phase_e        phase_q, phase_d;
  logic [CntW-1:0]    tick_q, tick_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic [FrameW-1:0]  shift_q, shift_d, shift_nxt;
  logic               step, emit;
  logic [FrameW-1:0]  emit_frame;
  irpd_status_e       emit_status;

  logic               out_valid_q;
  logic [FrameW-1:0]  out_frame_q;
  irpd_status_e       out_status_q;

  // advance one sample whenever the result slot is free or draining
  assign step    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = step;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    emit        = 1'b0;
    emit_frame  = '0;
    emit_status = ST_OK;
    shift_nxt   = shift_q;
    if (step) begin
      case (phase_q)
        PH_LEADER: begin
          if (!q_level_i) begin
            tick_d = sat_inc(tick_q);
          end else if (!in_window(tick_q, cfg_i.leader_min, cfg_i.leader_max)) begin
            phase_d     = PH_IDLE;
            tick_d      = '0;
            emit        = 1'b1;
            emit_status = ST_LEADER;
          end else begin
            phase_d = PH_SPACE;
            tick_d  = CntW'(1);
          end
        end
        PH_SPACE: begin
          if (q_level_i) begin
            tick_d = sat_inc(tick_q);
          end else if (!in_window(tick_q, cfg_i.space_min, cfg_i.space_max)) begin
            phase_d     = PH_IDLE;
            tick_d      = '0;
            emit        = 1'b1;
            emit_status = ST_SPACE;
          end else begin
            phase_d = PH_MARK;
            bit_d   = '0;
            shift_d = '0;
          end
        end
        PH_MARK: begin
          if (q_level_i) begin
            phase_d = PH_HIGH;
            tick_d  = CntW'(1);
          end
        end
        PH_HIGH: begin
          if (q_level_i) begin
            tick_d = sat_inc(tick_q);
          end else begin
            if (in_window(tick_q, cfg_i.one_min, cfg_i.one_max)) begin
              shift_nxt = shift_q | (FrameW'(1) << bit_q);
            end
            shift_d = shift_nxt;
            if (bit_q == {BitIdxW{1'b1}}) begin
              phase_d    = PH_IDLE;
              tick_d     = '0;
              bit_d      = '0;
              emit       = 1'b1;
              emit_frame = shift_nxt;
              // byte-wise complement check on address and command
              emit_status = ((shift_nxt[7:0] == ~shift_nxt[15:8]) &&
                             (shift_nxt[23:16] == ~shift_nxt[31:24])) ? ST_OK : ST_COMPL;
            end else begin
              bit_d   = bit_q + 1'b1;
              phase_d = PH_MARK;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (!q_level_i) begin
            phase_d = PH_LEADER;
            tick_d  = CntW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      if (step && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_frame_q  <= emit_frame;
      out_status_q <= emit_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_o     = out_frame_q;
  assign status_o    = out_status_q;

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && emit |=> out_valid_q)
    else $error("result lost on emit");

  a_bad_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ST_LEADER || out_status_q == ST_SPACE)
      |-> out_frame_q == '0)
    else $error("timing failure result carries data");

  a_tick_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEADER || phase_q == PH_SPACE || phase_q == PH_HIGH)
      |-> tick_q != '0)
    else $error("tick count zero while timing");

  a_no_step_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !q_pop_o)
    else $error("sample consumed while result slot blocked");

endmodule

@@ sv/ir_pulse_distance_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// IR pulse-distance frame decoder core
// Decodes pulse-distance remote frames from one sampled line level per word.
// ----------------------------------------------------------------------------
// Accepts one line sample every clock cycle unless stalled. Samples enter a
// short queue (FifoDepth words); the engine consumes one per cycle unless the
// output stalls. A frame result (address, inverted address, command, inverted
// command, status) is loaded into the output register as the engine consumes
// the sample that ends it. Input stalls only when the queue fills, which only
// happens while a result sits stalled at the output. Timing windows are strict
// and are to be written through the config port while idle (not enforced).
module ir_pulse_distance_frame_decoder_core #(
  parameter int unsigned FifoDepth = irpd_pkg::FifoDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [irpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [irpd_pkg::CntW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        ir_level_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  address_o,
  output logic [7:0]                  address_inv_o,
  output logic [7:0]                  command_o,
  output logic [7:0]                  command_inv_o,
  output logic [1:0]                  status_o
);
  import irpd_pkg::*;

  irpd_cfg_t         cfg_q;
  logic              q_valid, q_level, q_pop;
  logic [FrameW-1:0] frame;
  irpd_status_e      status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_min <= LeaderMinRst;
      cfg_q.leader_max <= LeaderMaxRst;
      cfg_q.space_min  <= SpaceMinRst;
      cfg_q.space_max  <= SpaceMaxRst;
      cfg_q.one_min    <= OneMinRst;
      cfg_q.one_max    <= OneMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEADER_MIN: cfg_q.leader_min <= cfg_data_i;
        REG_LEADER_MAX: cfg_q.leader_max <= cfg_data_i;
        REG_SPACE_MIN:  cfg_q.space_min  <= cfg_data_i;
        REG_SPACE_MAX:  cfg_q.space_max  <= cfg_data_i;
        REG_ONE_MIN:    cfg_q.one_min    <= cfg_data_i;
        REG_ONE_MAX:    cfg_q.one_max    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  irpd_sample_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ir_level_i (ir_level_i),
    .q_valid_o  (q_valid),
    .q_level_o  (q_level),
    .q_pop_i    (q_pop)
  );

  irpd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_level_i   (q_level),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_o     (frame),
    .status_o    (status)
  );

  assign address_o     = frame[7:0];
  assign address_inv_o = frame[15:8];
  assign command_o     = frame[23:16];
  assign command_inv_o = frame[31:24];
  assign status_o      = status;

endmodule
